FILE: sv/bsw_pkg.sv
// constants, state type and modular add for the bounded step walk counter
// no dependencies; used by bounded_step_walk_counter
package bsw_pkg;

  localparam int LEN_W    = 17;
  localparam int SPAN_W   = 6;
  localparam int COUNT_W  = 30;
  localparam int IDX_W    = SPAN_W + 1;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 32;
  localparam int MAX_LEVELS = 1 << SPAN_W;

  localparam logic [COUNT_W-1:0] PRIME = COUNT_W'(1000000007);

  // control states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_STEP = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  // sum of two residues, reduced once
  function automatic logic [COUNT_W-1:0] add_mod(input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PRIME}) begin
      s = s - {1'b0, PRIME};
    end
    return s[COUNT_W-1:0];
  endfunction

endpackage

FILE: sv/bounded_step_walk_counter.sv
// bounded step walk counter: row of per-level counts in a two-bank memory
// depends on bsw_pkg

// Counts sequences of walk_length levels in 0..level_span whose neighbours
// differ by one, modulo 1000000007. The row of level counts sits in a
// 128-entry memory split into two banks; each row update sweeps the source
// bank one entry per cycle through the single read port and writes the new
// row into the other bank. One request is in work at a time; the next word
// is taken while a finished result waits at the output register.
module bounded_step_walk_counter (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [bsw_pkg::IN_W-1:0]  s_axis_tdata,   // walk_length[16:0], level_span[22:17], zero
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [bsw_pkg::OUT_W-1:0] m_axis_tdata    // walk_count[29:0], zero
);

  bsw_pkg::state_t state;

  logic [bsw_pkg::LEN_W-1:0]   steps_left;
  logic [bsw_pkg::SPAN_W-1:0]  span;
  logic [bsw_pkg::IDX_W-1:0]   idx;
  logic [bsw_pkg::COUNT_W-1:0] acc;
  logic [bsw_pkg::COUNT_W-1:0] out_count;
  logic                        cur;
  logic                        ones;

  logic [bsw_pkg::COUNT_W-1:0] p1;
  logic [bsw_pkg::COUNT_W-1:0] p2;
  logic [bsw_pkg::COUNT_W-1:0] rdata;

  logic [bsw_pkg::COUNT_W-1:0] mem [0:2*bsw_pkg::MAX_LEVELS-1];

  logic [bsw_pkg::LEN_W-1:0]   in_len;
  logic [bsw_pkg::SPAN_W-1:0]  in_span;
  logic [bsw_pkg::IDX_W-1:0]   span_ext;
  logic [bsw_pkg::IDX_W-1:0]   wr_idx;
  logic [bsw_pkg::COUNT_W-1:0] cur_val;
  logic [bsw_pkg::COUNT_W-1:0] lo;
  logic [bsw_pkg::COUNT_W-1:0] hi;
  logic [bsw_pkg::COUNT_W-1:0] new_val;
  logic                        mem_we;
  logic                        step_end;
  logic                        sum_end;
  logic                        out_free;

  // port unpacking and handshake
  assign in_len        = s_axis_tdata[16:0];
  assign in_span       = s_axis_tdata[22:17];
  assign s_axis_tready = (state == bsw_pkg::ST_IDLE);
  assign m_axis_tdata  = {2'b00, out_count};
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // neighbour sum for the entry two behind the read pointer
  always_comb begin
    span_ext = {1'b0, span};
    wr_idx   = idx - bsw_pkg::IDX_W'(2);
    cur_val  = ones ? bsw_pkg::COUNT_W'(1) : rdata;
    lo       = (wr_idx != '0) ? p2 : '0;
    hi       = (wr_idx < span_ext) ? cur_val : '0;
    new_val  = bsw_pkg::add_mod(lo, hi);
    mem_we   = (state == bsw_pkg::ST_STEP) && (idx >= bsw_pkg::IDX_W'(2));
    step_end = (idx == span_ext + bsw_pkg::IDX_W'(2));
    sum_end  = (idx == span_ext + bsw_pkg::IDX_W'(1));
  end

  // row memory: bank bit on top, write to the bank not being read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{~cur, wr_idx[bsw_pkg::SPAN_W-1:0]}] <= new_val;
    end
    rdata <= mem[{cur, idx[bsw_pkg::SPAN_W-1:0]}];
  end

  // sliding window of the previous row
  always_ff @(posedge clk) begin
    p2 <= p1;
    p1 <= cur_val;
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bsw_pkg::ST_IDLE;
      steps_left    <= '0;
      idx           <= '0;
      acc           <= '0;
      cur           <= 1'b0;
      ones          <= 1'b0;
    end else begin
      case (state)
        bsw_pkg::ST_IDLE: begin
          if (s_axis_tvalid) begin
            span <= in_span;
            acc  <= '0;
            ones <= 1'b1;
            cur  <= 1'b0;
            idx  <= '0;
            steps_left <= in_len - bsw_pkg::LEN_W'(1);
            if (in_len == '0) begin
              state <= bsw_pkg::ST_DONE;
            end else if (in_len == bsw_pkg::LEN_W'(1)) begin
              state <= bsw_pkg::ST_SUM;
            end else begin
              state <= bsw_pkg::ST_STEP;
            end
          end
        end
        bsw_pkg::ST_STEP: begin
          idx <= idx + bsw_pkg::IDX_W'(1);
          if (step_end) begin
            idx        <= '0;
            cur        <= ~cur;
            ones       <= 1'b0;
            steps_left <= steps_left - bsw_pkg::LEN_W'(1);
            if (steps_left == bsw_pkg::LEN_W'(1)) begin
              state <= bsw_pkg::ST_SUM;
            end
          end
        end
        bsw_pkg::ST_SUM: begin
          idx <= idx + bsw_pkg::IDX_W'(1);
          if (idx != '0) begin
            acc <= bsw_pkg::add_mod(acc, cur_val);
          end
          if (sum_end) begin
            state <= bsw_pkg::ST_DONE;
          end
        end
        bsw_pkg::ST_DONE: begin
          if (out_free) begin
            state <= bsw_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= bsw_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == bsw_pkg::ST_DONE) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if ((state == bsw_pkg::ST_DONE) && out_free) begin
      out_count <= acc;
    end
  end

`ifndef SYNTHESIS
  a_out_reduced: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[29:0] < bsw_pkg::PRIME))
    else $error("result word not reduced");

  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    acc < bsw_pkg::PRIME)
    else $error("running sum not reduced");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == bsw_pkg::ST_STEP) |-> (idx <= span_ext + bsw_pkg::IDX_W'(2)))
    else $error("row sweep ran past the span");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state != bsw_pkg::ST_IDLE))
    else $error("request dropped after accept");

  a_done_leaves: assert property (@(posedge clk) disable iff (rst)
    ((state == bsw_pkg::ST_DONE) && out_free) |=> (m_axis_tvalid &&
      (state == bsw_pkg::ST_IDLE)))
    else $error("result not posted");
`endif

endmodule

FILE: sim/tb_top.sv
// self-checking testbench for bounded_step_walk_counter: directed edge cases,
// one longest walk, random and back-to-back requests, random idling both sides
// depends on bsw_pkg and bounded_step_walk_counter
module tb_top;

  localparam int LEN_W   = bsw_pkg::LEN_W;
  localparam int SPAN_W  = bsw_pkg::SPAN_W;
  localparam int COUNT_W = bsw_pkg::COUNT_W;
  localparam int LEVELS  = bsw_pkg::MAX_LEVELS;

  localparam logic [COUNT_W:0] WALK_MOD = 31'd1000000007;

  // limit on cycles with no word moving, above the run time of the longest request
  localparam int WATCHDOG_LIMIT = 3000000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int MAX_REPORTS    = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // walk_length[16:0], level_span[22:17], zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // walk_count[29:0], zero

  logic [COUNT_W-1:0] expected_counts [$];
  int fail_count   = 0;
  int idle_cycles  = 0;
  bit tx_no_idle   = 1'b0;
  bit rx_no_idle   = 1'b0;

  bounded_step_walk_counter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // residue sum, one reduction
  function automatic logic [COUNT_W-1:0] mod_sum(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= WALK_MOD) begin
      s = s - WALK_MOD;
    end
    return s[COUNT_W-1:0];
  endfunction

  // number of walks of len levels over 0..span, neighbours one apart
  function automatic logic [COUNT_W-1:0] count_walks(input logic [LEN_W-1:0] len,
                                                     input logic [SPAN_W-1:0] span);
    logic [COUNT_W-1:0] row [0:LEVELS-1];
    logic [COUNT_W-1:0] nxt [0:LEVELS-1];
    logic [COUNT_W-1:0] lo;
    logic [COUNT_W-1:0] hi;
    logic [COUNT_W-1:0] total;
    int top;
    int i;
    int step;
    top = int'(span);
    total = '0;
    if (len == '0) begin
      return '0;
    end
    // every level starts a single-level walk
    for (i = 0; i < LEVELS; i++) begin
      row[i] = (i <= top) ? COUNT_W'(1) : '0;
      nxt[i] = '0;
    end
    for (step = 1; step < int'(len); step++) begin
      for (i = 0; i <= top; i++) begin
        lo = (i > 0) ? row[i-1] : '0;
        hi = (i < top) ? row[i+1] : '0;
        nxt[i] = mod_sum(lo, hi);
      end
      for (i = 0; i <= top; i++) begin
        row[i] = nxt[i];
      end
    end
    for (i = 0; i <= top; i++) begin
      total = mod_sum(total, row[i]);
    end
    return total;
  endfunction

  // send one request word and queue its count once accepted
  task automatic send_walk(input int len, input int span);
    logic [LEN_W-1:0]   len_f;
    logic [SPAN_W-1:0]  span_f;
    logic [COUNT_W-1:0] want;
    int gap;
    len_f  = len[LEN_W-1:0];
    span_f = span[SPAN_W-1:0];
    want   = count_walks(len_f, span_f);
    gap    = tx_no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, span_f, len_f};
    do @(posedge clk); while (!s_axis_tready);
    expected_counts.push_back(want);
  endtask

  task automatic note_failure(input string what, input logic [COUNT_W-1:0] want,
                              input logic [COUNT_W-1:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("mismatch: %s expected %0d got %0d", what, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_counts.size() == 0) begin
        note_failure("unexpected result word", '0, m_axis_tdata[COUNT_W-1:0]);
      end else begin
        logic [COUNT_W-1:0] want;
        want = expected_counts.pop_front();
        if (m_axis_tdata[COUNT_W-1:0] !== want) begin
          note_failure("walk_count", want, m_axis_tdata[COUNT_W-1:0]);
        end
      end
    end
  end

  // receiver back-pressure
  initial begin
    int gap;
    wait (!rst);
    @(posedge clk);
    forever begin
      gap = rx_no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // zero and unit lengths, span extremes, alternating bit patterns
  task automatic test_length_edges();
    send_walk(0, 0);
    send_walk(0, 63);
    send_walk(1, 0);
    send_walk(1, 63);
    send_walk(1, 42);
    send_walk(2, 0);
    send_walk(2, 1);
    send_walk(2, 63);
    send_walk(3, 0);
    send_walk(3, 1);
    send_walk(3, 63);
    send_walk(4, 63);
    send_walk(7, 21);
    send_walk(16, 63);
    send_walk(21, 42);
    send_walk(64, 63);
    send_walk(100, 5);
  endtask

  // full-scale length on a narrow span keeps the run short
  task automatic test_longest_walk();
    send_walk((1 << LEN_W) - 1, 2);
  endtask

  // mostly short walks over any span, some tiny and some longer narrow ones
  task automatic test_random_walks();
    int n;
    int pick;
    for (n = 0; n < 60; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        send_walk($urandom_range(1, 48), $urandom_range(0, 63));
      end else if (pick < 8) begin
        send_walk($urandom_range(0, 2), $urandom_range(0, 63));
      end else begin
        send_walk($urandom_range(49, 400), $urandom_range(0, 7));
      end
    end
  endtask

  // sender never idles; receiver stalls first, then neither side idles
  task automatic test_back_to_back();
    int n;
    tx_no_idle = 1'b1;
    for (n = 0; n < 40; n++) begin
      if (n == 20) begin
        rx_no_idle = 1'b1;
      end
      send_walk($urandom_range(0, 32), $urandom_range(0, 63));
    end
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  // sequence
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_length_edges();
    test_longest_walk();
    test_random_walks();
    test_back_to_back();
    s_axis_tvalid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/bsw_pkg.sv
sv/bounded_step_walk_counter.sv
sim/tb_top.sv
